FILE: sv/rv32i_execute_unit_top_defines.svh
// Assertion macros used by the port-level checker of the execute unit.
`ifndef RV32I_EXECUTE_UNIT_TOP_DEFINES_SVH
`define RV32I_EXECUTE_UNIT_TOP_DEFINES_SVH
// Checks that a condition implies a second one at the same clock edge.
`define RVX_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Checks that a condition implies a second one at the next clock edge.
`define RVX_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

FILE: sv/rvx_pkg.sv
// Package with the operation codes, queue entry type, result type and constants of the execute unit.
`default_nettype none
package rvx_pkg;
    localparam int DefaultDataWords = 1024;
    localparam logic [31:0] PcStep = 32'd4;
    localparam logic [4:0] ShamtMask = 5'b11111;
    localparam int UpperShift = 12;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_ADDI = 5'd1, OP_SUB = 5'd2, OP_AND = 5'd3, OP_ANDI = 5'd4,
        OP_OR = 5'd5, OP_ORI = 5'd6, OP_XOR = 5'd7, OP_XORI = 5'd8, OP_SLL = 5'd9,
        OP_SLLI = 5'd10, OP_SRL = 5'd11, OP_SRLI = 5'd12, OP_SRA = 5'd13, OP_SRAI = 5'd14,
        OP_LUI = 5'd15, OP_AUIPC = 5'd16, OP_SLT = 5'd17, OP_SLTI = 5'd18, OP_SLTU = 5'd19,
        OP_SLTIU = 5'd20, OP_BEQ = 5'd21, OP_BNE = 5'd22, OP_BLT = 5'd23, OP_BGE = 5'd24,
        OP_BLTU = 5'd25, OP_BGEU = 5'd26, OP_JAL = 5'd27, OP_JALR = 5'd28, OP_LW = 5'd29,
        OP_SW = 5'd30, OP_NOP = 5'd31
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic        use_imm;
        logic        writes_rd;
    } entry_t;

    typedef struct packed {
        logic [31:0] written_value;
        logic [4:0]  written_reg;
        logic [31:0] next_pc;
        logic        jumped;
        logic        stored;
    } result_t;
endpackage
`default_nettype wire

FILE: sv/rvx_stream_if.sv
// Valid/ready channel interface carrying one payload item.
`default_nettype none
interface rvx_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/rvx_front.sv
// Front part: accepts instructions, classifies them and keeps a two-entry queue.
`default_nettype none
module rvx_front
    import rvx_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire entry_t in_entry,
    output logic        q_valid,
    input  wire logic   q_ready,
    output entry_t      q_entry
);
    entry_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    entry_t     cls;
    logic       push, pop;

    always_comb
    begin
        cls = in_entry;
        cls.use_imm = 1'b0;
        cls.writes_rd = 1'b1;
        unique case (in_entry.op) inside
            OP_ADDI, OP_ANDI, OP_ORI, OP_XORI, OP_SLLI, OP_SRLI, OP_SRAI, OP_SLTI,
            OP_SLTIU: cls.use_imm = 1'b1;
            OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU, OP_SW, OP_NOP:
                cls.writes_rd = 1'b0;
            default: ;
        endcase
        if (in_entry.rd == 5'd0)
        begin
            cls.writes_rd = 1'b0;
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

FILE: sv/rvx_back.sv
// Back part: register file, program counter, ALU, data memory and result register.
`default_nettype none
module rvx_back
    import rvx_pkg::*;
#(
    parameter int DATA_WORDS = DefaultDataWords
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    output logic        q_ready,
    input  wire entry_t q_entry,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     out_result
);
    localparam int AddrBits = $clog2(DATA_WORDS);

    logic [31:0]         regs_reg [32];
    logic [31:0]         pc_reg;
    logic [31:0]         dmem [DATA_WORDS];
    logic                valid_reg;
    logic                valid_next;
    result_t             res_reg;
    logic                load_pend_reg;
    logic [31:0]         load_word_reg;
    logic                clr_busy_reg;
    logic [AddrBits-1:0] clr_idx_reg;

    logic [31:0] a, b, opb, sum, addr, val, next;
    logic [4:0]  sh;
    logic        take, jmp, st, fire, slt, sltu;
    logic [AddrBits-1:0] widx;

    // While a load is pending, no new item is taken until the registered memory read is written back.
    assign q_ready = (!valid_reg || out_ready) && !load_pend_reg && !clr_busy_reg;
    assign fire = q_valid && q_ready;

    always_comb
    begin
        a = (q_entry.rs1 == 5'd0) ? 32'd0 : regs_reg[q_entry.rs1];
        b = (q_entry.rs2 == 5'd0) ? 32'd0 : regs_reg[q_entry.rs2];
        opb = q_entry.use_imm ? q_entry.imm : b;
        sh = opb[4:0] & ShamtMask;
        sum = a + q_entry.imm;
        addr = sum;
        widx = addr[AddrBits+1:2];
        slt = $signed(a) < $signed(opb);
        sltu = a < opb;
        next = pc_reg + PcStep;
        val = 32'd0;
        take = 1'b0;
        jmp = 1'b0;
        st = 1'b0;
        unique case (q_entry.op)
            OP_ADD, OP_ADDI: val = a + opb;
            OP_SUB: val = a - b;
            OP_AND, OP_ANDI: val = a & opb;
            OP_OR, OP_ORI: val = a | opb;
            OP_XOR, OP_XORI: val = a ^ opb;
            OP_SLL, OP_SLLI: val = a << sh;
            OP_SRL, OP_SRLI: val = a >> sh;
            OP_SRA, OP_SRAI: val = $unsigned($signed(a) >>> sh);
            OP_LUI: val = q_entry.imm << UpperShift;
            OP_AUIPC: val = pc_reg + (q_entry.imm << UpperShift);
            OP_SLT, OP_SLTI: val = {31'd0, slt};
            OP_SLTU, OP_SLTIU: val = {31'd0, sltu};
            OP_BEQ: take = (a == b);
            OP_BNE: take = (a != b);
            OP_BLT: take = slt;
            OP_BGE: take = !slt;
            OP_BLTU: take = sltu;
            OP_BGEU: take = !sltu;
            OP_JAL:
            begin
                val = pc_reg + PcStep;
                next = pc_reg + q_entry.imm;
                jmp = 1'b1;
            end
            OP_JALR:
            begin
                val = pc_reg + PcStep;
                next = sum & ~32'd1;
                jmp = 1'b1;
            end
            OP_SW:
            begin
                val = b;
                st = 1'b1;
            end
            default: ;
        endcase
        if (take)
        begin
            next = pc_reg + q_entry.imm;
            jmp = 1'b1;
        end
        if (!q_entry.writes_rd && q_entry.op != OP_SW)
        begin
            val = 32'd0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load_pend_reg)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = (q_entry.op != OP_LW);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            dmem[clr_idx_reg] <= 32'd0;
        end
        else if (fire && st)
        begin
            dmem[widx] <= b;
        end
        load_word_reg <= dmem[widx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == AddrBits'(DATA_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            load_pend_reg <= 1'b0;
            pc_reg <= 32'd0;
            res_reg <= '0;
            for (int i = 0; i < 32; i++) regs_reg[i] <= 32'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load_pend_reg)
            begin
                load_pend_reg <= 1'b0;
                if (res_reg.written_reg != 5'd0)
                begin
                    res_reg.written_value <= load_word_reg;
                    regs_reg[res_reg.written_reg] <= load_word_reg;
                end
            end
            if (fire)
            begin
                pc_reg <= next;
                res_reg.written_value <= val;
                res_reg.written_reg <= q_entry.writes_rd ? q_entry.rd : 5'd0;
                res_reg.next_pc <= next;
                res_reg.jumped <= jmp;
                res_reg.stored <= st;
                if (q_entry.op == OP_LW)
                begin
                    load_pend_reg <= 1'b1;
                end
                else
                begin
                    if (q_entry.writes_rd) regs_reg[q_entry.rd] <= val;
                end
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_result = res_reg;
endmodule
`default_nettype wire

FILE: sv/rv32i_execute_unit_top.sv
// Top level of the RV32I execute unit: front queue and back execute stage.
// Executes one decoded instruction per item; ALU, branch, jump and store items run back to back
// while the output is not held, while LW holds off the next item because the data memory read is
// registered. A two-entry queue separates the accepting front from the executing back. After
// reset the back clears the data memory one word per cycle; while it clears, items are only
// queued and no item is executed.
`default_nettype none
module rv32i_execute_unit_top
    import rvx_pkg::*;
#(
    parameter int DATA_WORDS = DefaultDataWords
)
(
    input wire logic clk,
    input wire logic rst_n,
    rvx_stream_if.sink   in_ch,
    rvx_stream_if.source out_ch
);
    logic   q_valid, q_ready;
    entry_t q_entry;
    entry_t in_entry;

    always_comb
    begin
        in_entry = in_ch.payload;
        in_entry.use_imm = 1'b0;
        in_entry.writes_rd = 1'b0;
    end

    rvx_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_entry(in_entry),
        .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry)
    );

    rvx_back #(.DATA_WORDS(DATA_WORDS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_result(out_ch.payload)
    );
endmodule
`default_nettype wire

FILE: sv/rvx_checker.sv
// Port-level checker for the execute unit, bound to the top level.
`default_nettype none
`include "rv32i_execute_unit_top_defines.svh"
module rvx_checker
    import rvx_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire result_t out_result
);
    logic held, shown_store, store_clean, shown_quiet;

    assign held = out_valid && !out_ready;
    assign shown_store = out_valid && out_result.stored;
    assign store_clean = (out_result.written_reg == 5'd0) && !out_result.jumped;
    assign shown_quiet = out_valid && (out_result.written_reg == 5'd0) && !out_result.stored;

    `RVX_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid && $stable(out_result))
    `RVX_ASSERT_IMPL(a_store_no_reg, clk, rst_n, shown_store, store_clean)
    `RVX_ASSERT_IMPL(a_no_reg_zero, clk, rst_n, shown_quiet, out_result.written_value == 32'd0)
endmodule

bind rv32i_execute_unit_top rvx_checker u_rvx_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_result(out_ch.payload)
);
`default_nettype wire

FILE: bench/rvx_execute_checker.sv
// Checker that predicts every executed instruction item and compares the results.
`timescale 1ns / 100ps
module rvx_execute_checker
    import rvx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_ready,
    input  entry_t  in_item,
    input  logic    out_valid,
    input  logic    out_ready,
    input  result_t out_item,
    output int      errors,
    output int      pending
);
    localparam int MemWords = DefaultDataWords;

    logic [31:0] regs [32];
    logic [31:0] pc;
    logic [31:0] mem [MemWords];
    result_t     pending_results [$];

    assign pending = pending_results.size();

    function automatic logic [31:0] mem_index(input logic [31:0] addr);
        return (addr >> 2) % MemWords;
    endfunction

    task automatic execute_instr(input entry_t e, output result_t r);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] val;
        logic [31:0] nxt;
        logic        wr;
        logic        jmp;
        logic        st;
        logic        take;
        a = (e.rs1 == 5'd0) ? 32'd0 : regs[e.rs1];
        b = (e.rs2 == 5'd0) ? 32'd0 : regs[e.rs2];
        imm = e.imm;
        val = 32'd0;
        nxt = pc + PcStep;
        wr = 1'b1;
        jmp = 1'b0;
        st = 1'b0;
        take = 1'b0;
        case (e.op)
            OP_ADD:   val = a + b;
            OP_ADDI:  val = a + imm;
            OP_SUB:   val = a - b;
            OP_AND:   val = a & b;
            OP_ANDI:  val = a & imm;
            OP_OR:    val = a | b;
            OP_ORI:   val = a | imm;
            OP_XOR:   val = a ^ b;
            OP_XORI:  val = a ^ imm;
            OP_SLL:   val = a << (b[4:0] & ShamtMask);
            OP_SLLI:  val = a << (imm[4:0] & ShamtMask);
            OP_SRL:   val = a >> (b[4:0] & ShamtMask);
            OP_SRLI:  val = a >> (imm[4:0] & ShamtMask);
            OP_SRA:   val = $signed(a) >>> (b[4:0] & ShamtMask);
            OP_SRAI:  val = $signed(a) >>> (imm[4:0] & ShamtMask);
            OP_LUI:   val = imm << UpperShift;
            OP_AUIPC: val = pc + (imm << UpperShift);
            OP_SLT:   val = {31'd0, $signed(a) < $signed(b)};
            OP_SLTI:  val = {31'd0, $signed(a) < $signed(imm)};
            OP_SLTU:  val = {31'd0, a < b};
            OP_SLTIU: val = {31'd0, a < imm};
            OP_BEQ:   begin wr = 1'b0; take = (a == b); end
            OP_BNE:   begin wr = 1'b0; take = (a != b); end
            OP_BLT:   begin wr = 1'b0; take = $signed(a) < $signed(b); end
            OP_BGE:   begin wr = 1'b0; take = !($signed(a) < $signed(b)); end
            OP_BLTU:  begin wr = 1'b0; take = (a < b); end
            OP_BGEU:  begin wr = 1'b0; take = (a >= b); end
            OP_JAL:
            begin
                val = pc + PcStep;
                nxt = pc + imm;
                jmp = 1'b1;
            end
            OP_JALR:
            begin
                val = pc + PcStep;
                nxt = (a + imm) & ~32'd1;
                jmp = 1'b1;
            end
            OP_LW:    val = mem[mem_index(a + imm)];
            OP_SW:
            begin
                wr = 1'b0;
                val = b;
                mem[mem_index(a + imm)] = b;
                st = 1'b1;
            end
            default:  wr = 1'b0;
        endcase
        if (take)
        begin
            nxt = pc + imm;
            jmp = 1'b1;
        end
        if (wr && e.rd == 5'd0)
        begin
            wr = 1'b0;
            val = 32'd0;
        end
        if (wr)
            regs[e.rd] = val;
        pc = nxt;
        r.written_value = val;
        r.written_reg = wr ? e.rd : 5'd0;
        r.next_pc = nxt;
        r.jumped = jmp;
        r.stored = st;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t exp_r;
        result_t new_r;
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                regs[i] = 32'd0;
            for (int i = 0; i < MemWords; i++)
                mem[i] = 32'd0;
            pc = 32'd0;
            pending_results.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, out_item);
                    errors++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.written_value !== out_item.written_value)
                    begin
                        $display("%0t: written_value expected %h actual %h", $time,
                                 exp_r.written_value, out_item.written_value);
                        errors++;
                    end
                    if (exp_r.written_reg !== out_item.written_reg)
                    begin
                        $display("%0t: written_reg expected %0d actual %0d", $time,
                                 exp_r.written_reg, out_item.written_reg);
                        errors++;
                    end
                    if (exp_r.next_pc !== out_item.next_pc)
                    begin
                        $display("%0t: next_pc expected %h actual %h", $time,
                                 exp_r.next_pc, out_item.next_pc);
                        errors++;
                    end
                    if (exp_r.jumped !== out_item.jumped)
                    begin
                        $display("%0t: jumped expected %b actual %b", $time,
                                 exp_r.jumped, out_item.jumped);
                        errors++;
                    end
                    if (exp_r.stored !== out_item.stored)
                    begin
                        $display("%0t: stored expected %b actual %b", $time,
                                 exp_r.stored, out_item.stored);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                execute_instr(in_item, new_r);
                pending_results.push_back(new_r);
            end
        end
    end
endmodule

FILE: bench/tb_rv32i_execute_unit_top.sv
// Testbench top: drives instruction items into the execute unit and gives the verdict.
`timescale 1ns / 100ps
module tb_rv32i_execute_unit_top;
    import rvx_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic long_hold_go;
    int   hold_left;

    rvx_stream_if #(.payload_t(entry_t))  in_ch ();
    rvx_stream_if #(.payload_t(result_t)) out_ch ();

    rv32i_execute_unit_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    rvx_execute_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_ch.payload),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.payload),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        hold_left = 0;
    end

    always @(posedge clk)
    begin
        if (long_hold_go && hold_left == 0)
            hold_left = 300;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic entry_t make_instr(input op_t op, input logic [4:0] rd,
                                          input logic [4:0] rs1, input logic [4:0] rs2,
                                          input logic [31:0] imm);
        entry_t e;
        e.op = op;
        e.rd = rd;
        e.rs1 = rs1;
        e.rs2 = rs2;
        e.imm = imm;
        e.use_imm = op inside {OP_ADDI, OP_ANDI, OP_ORI, OP_XORI, OP_SLLI, OP_SRLI, OP_SRAI,
                               OP_LUI, OP_AUIPC, OP_SLTI, OP_SLTIU, OP_JAL, OP_JALR,
                               OP_LW, OP_SW};
        e.writes_rd = !(op inside {OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
                                   OP_SW, OP_NOP});
        return e;
    endfunction

    task automatic send(input entry_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= e;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random();
        op_t         op;
        logic [31:0] imm;
        logic [4:0]  rs1;
        op = op_t'($urandom_range(31));
        imm = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(4095)) - 2048);
        rs1 = 5'($urandom_range(31));
        if ((op == OP_LW || op == OP_SW) && $urandom_range(1))
        begin
            rs1 = 5'd0;
            imm = 32'($urandom_range(63) * 4 + $urandom_range(3));
        end
        send(make_instr(op, 5'($urandom_range(31)), rs1, 5'($urandom_range(31)), imm));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        long_hold_go = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 62;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_instr(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF));
        send(make_instr(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'h8000_0000));
        send(make_instr(OP_ADDI, 5'd31, 5'd0, 5'd0, 32'hFFFF_FFFF));
        send(make_instr(OP_ADDI, 5'd0, 5'd1, 5'd0, 32'd5));
        send(make_instr(OP_ADD, 5'd3, 5'd1, 5'd1, 32'd0));
        send(make_instr(OP_SUB, 5'd4, 5'd2, 5'd1, 32'd0));
        send(make_instr(OP_AND, 5'd5, 5'd31, 5'd2, 32'd0));
        send(make_instr(OP_ORI, 5'd6, 5'd2, 5'd0, 32'h0000_0FFF));
        send(make_instr(OP_XOR, 5'd7, 5'd31, 5'd1, 32'd0));
        send(make_instr(OP_SLLI, 5'd8, 5'd31, 5'd0, 32'hFFFF_FFFF));
        send(make_instr(OP_SRL, 5'd9, 5'd2, 5'd31, 32'd0));
        send(make_instr(OP_SRAI, 5'd10, 5'd2, 5'd0, 32'h0000_0021));
        send(make_instr(OP_SRA, 5'd11, 5'd31, 5'd1, 32'd0));
        send(make_instr(OP_LUI, 5'd12, 5'd0, 5'd0, 32'hFFFF_FFFF));
        send(make_instr(OP_AUIPC, 5'd13, 5'd0, 5'd0, 32'h000F_FFFF));
        send(make_instr(OP_SLT, 5'd14, 5'd2, 5'd1, 32'd0));
        send(make_instr(OP_SLTIU, 5'd15, 5'd1, 5'd0, 32'hFFFF_FFFF));
        send(make_instr(OP_BEQ, 5'd0, 5'd1, 5'd1, 32'hFFFF_FFF0));
        send(make_instr(OP_BNE, 5'd0, 5'd1, 5'd1, 32'd64));
        send(make_instr(OP_BLT, 5'd0, 5'd2, 5'd1, 32'd8));
        send(make_instr(OP_BGEU, 5'd0, 5'd2, 5'd1, 32'd12));
        send(make_instr(OP_JAL, 5'd16, 5'd0, 5'd0, 32'h8000_0000));
        send(make_instr(OP_JALR, 5'd17, 5'd31, 5'd0, 32'd0));
        send(make_instr(OP_SW, 5'd0, 5'd31, 5'd2, 32'd1));
        send(make_instr(OP_LW, 5'd18, 5'd31, 5'd0, 32'd3));
        send(make_instr(OP_NOP, 5'd19, 5'd1, 5'd2, 32'hFFFF_FFFF));

        for (int i = 0; i < 150; i++)
            send_random();
        send_idle_pct = 62;
        recv_idle_pct = 34;
        for (int i = 0; i < 150; i++)
            send_random();

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_go <= 1'b1;
        for (int i = 0; i < 150; i++)
        begin
            if (i == 2)
                long_hold_go <= 1'b0;
            send_random();
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
